/* rtl/ggc_pkg.sv */
// ----------------------------------------------------------------------------
// ggc_pkg
// shared codes and controller/datapath link types for the greedy colouring table
// ----------------------------------------------------------------------------
package ggc_pkg;

    localparam int ACT_W    = 4;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 7;
    localparam int NCOUNT_W = 7;
    localparam int ECOUNT_W = 11;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ADD_NODE   = 4'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_EDGE   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_REM_NODE   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_REM_EDGE   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DEGREE     = 4'd4;
    localparam logic [ACT_W-1:0] ACT_MAX_DEGREE = 4'd5;
    localparam logic [ACT_W-1:0] ACT_COLOR      = 4'd6;
    localparam logic [ACT_W-1:0] ACT_READ_COLOR = 4'd7;
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd8;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // slot sweep kinds
    localparam logic [2:0] SCAN_NONE   = 3'd0;
    localparam logic [2:0] SCAN_LOOK   = 3'd1;
    localparam logic [2:0] SCAN_MAXDEG = 3'd2;
    localparam logic [2:0] SCAN_RANK   = 3'd3;
    localparam logic [2:0] SCAN_NEIGH  = 3'd4;
    localparam logic [2:0] SCAN_REMOVE = 3'd5;

    // point read select
    localparam logic [1:0] RD_A = 2'd0;
    localparam logic [1:0] RD_B = 2'd1;
    localparam logic [1:0] RD_S = 2'd2;

    // result value select
    localparam logic [1:0] VS_ZERO = 2'd0;
    localparam logic [1:0] VS_DEG  = 2'd1;
    localparam logic [1:0] VS_COL  = 2'd2;
    localparam logic [1:0] VS_MAX  = 2'd3;

    typedef struct packed {
        logic                load;
        logic [2:0]          scan;
        logic [1:0]          rd_sel;
        logic                create_a;
        logic                create_b;
        logic                link_wr;
        logic                link_b;
        logic                edge_fin;
        logic                rem_take;
        logic                rem_fin;
        logic                color_init;
        logic                rank_clr;
        logic                rank_inc;
        logic                row_take;
        logic                pick_init;
        logic                pick_step;
        logic                col_wr;
        logic                clear_all;
        logic                res_we;
        logic [STATUS_W-1:0] res_st;
        logic [1:0]          res_vsel;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             fa;
        logic             fb;
        logic [1:0]       nf;
        logic             a_eq_b;
        logic             bit_ab;
        logic             scan_done;
        logic             rank_end;
        logic             fs;
        logic             pick_done;
        logic             out_free;
    } t_sts;

endpackage

/* rtl/ggc_ctrl.sv */
// ----------------------------------------------------------------------------
// ggc_ctrl
// sequencer that steps the datapath through each action
// ----------------------------------------------------------------------------
module ggc_ctrl import ggc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_START   = 5'd1;
    localparam logic [4:0] S_LOOK    = 5'd2;
    localparam logic [4:0] S_DISP    = 5'd3;
    localparam logic [4:0] S_CHK     = 5'd4;
    localparam logic [4:0] S_NEW_B   = 5'd5;
    localparam logic [4:0] S_L_RDA   = 5'd6;
    localparam logic [4:0] S_L_WRA   = 5'd7;
    localparam logic [4:0] S_L_WRB   = 5'd8;
    localparam logic [4:0] S_R_RD    = 5'd9;
    localparam logic [4:0] S_R_SWEEP = 5'd10;
    localparam logic [4:0] S_VAL     = 5'd11;
    localparam logic [4:0] S_MAX     = 5'd12;
    localparam logic [4:0] S_C_CHK   = 5'd13;
    localparam logic [4:0] S_C_SCAN  = 5'd14;
    localparam logic [4:0] S_C_SEL   = 5'd15;
    localparam logic [4:0] S_C_ROW   = 5'd16;
    localparam logic [4:0] S_C_NEIGH = 5'd17;
    localparam logic [4:0] S_C_PICK  = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.scan   = SCAN_NONE;
        o_cmd.rd_sel = RD_A;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                unique case (i_sts.act) inside
                    ACT_ADD_NODE, ACT_ADD_EDGE, ACT_REM_NODE, ACT_REM_EDGE,
                    ACT_DEGREE, ACT_READ_COLOR: begin
                        n_state = S_LOOK;
                    end
                    ACT_MAX_DEGREE, ACT_COLOR: begin
                        n_state = S_MAX;
                    end
                    ACT_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                        o_cmd.res_we    = 1'b1;
                        o_cmd.res_st    = ST_OK;
                        n_state         = S_DONE;
                    end
                    default: begin
                        o_cmd.res_we = 1'b1;
                        o_cmd.res_st = ST_REJECT;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_LOOK: begin
                o_cmd.scan = SCAN_LOOK;
                if (i_sts.scan_done) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.rd_sel = RD_A;
                unique case (i_sts.act) inside
                    ACT_ADD_NODE: begin
                        o_cmd.res_we = 1'b1;
                        n_state      = S_DONE;
                        if (i_sts.fa) begin
                            o_cmd.res_st = ST_REJECT;
                        end else if (i_sts.nf == 2'd0) begin
                            o_cmd.res_st = ST_FULL;
                        end else begin
                            o_cmd.create_a = 1'b1;
                            o_cmd.res_st   = ST_OK;
                        end
                    end
                    ACT_ADD_EDGE: begin
                        if (i_sts.a_eq_b) begin
                            o_cmd.res_we = 1'b1;
                            o_cmd.res_st = ST_REJECT;
                            n_state      = S_DONE;
                        end else if (i_sts.fa && i_sts.fb) begin
                            n_state = S_CHK;
                        end else if ((!i_sts.fa && !i_sts.fb) ? (i_sts.nf != 2'd2)
                                                              : (i_sts.nf == 2'd0)) begin
                            o_cmd.res_we = 1'b1;
                            o_cmd.res_st = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.create_a = !i_sts.fa;
                            n_state        = S_NEW_B;
                        end
                    end
                    ACT_REM_NODE: begin
                        if (!i_sts.fa) begin
                            o_cmd.res_we = 1'b1;
                            o_cmd.res_st = ST_NOT_FOUND;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_R_RD;
                        end
                    end
                    ACT_REM_EDGE: begin
                        if (!i_sts.fa || !i_sts.fb) begin
                            o_cmd.res_we = 1'b1;
                            o_cmd.res_st = ST_NOT_FOUND;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_CHK;
                        end
                    end
                    ACT_DEGREE, ACT_READ_COLOR: begin
                        if (!i_sts.fa) begin
                            o_cmd.res_we = 1'b1;
                            o_cmd.res_st = ST_NOT_FOUND;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_VAL;
                        end
                    end
                    default: begin
                        o_cmd.res_we = 1'b1;
                        o_cmd.res_st = ST_REJECT;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_CHK: begin
                if (i_sts.act == ACT_ADD_EDGE) begin
                    if (i_sts.bit_ab) begin
                        o_cmd.res_we = 1'b1;
                        o_cmd.res_st = ST_REJECT;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_L_RDA;
                    end
                end else begin
                    if (!i_sts.bit_ab) begin
                        o_cmd.res_we = 1'b1;
                        o_cmd.res_st = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_L_RDA;
                    end
                end
            end
            S_NEW_B: begin
                o_cmd.create_b = !i_sts.fb;
                n_state        = S_L_RDA;
            end
            S_L_RDA: begin
                o_cmd.rd_sel = RD_A;
                n_state      = S_L_WRA;
            end
            S_L_WRA: begin
                o_cmd.link_wr = 1'b1;
                o_cmd.rd_sel  = RD_B;
                n_state       = S_L_WRB;
            end
            S_L_WRB: begin
                o_cmd.link_wr  = 1'b1;
                o_cmd.link_b   = 1'b1;
                o_cmd.edge_fin = 1'b1;
                o_cmd.res_we   = 1'b1;
                o_cmd.res_st   = ST_OK;
                n_state        = S_DONE;
            end
            S_R_RD: begin
                o_cmd.rem_take = 1'b1;
                n_state        = S_R_SWEEP;
            end
            S_R_SWEEP: begin
                o_cmd.scan = SCAN_REMOVE;
                if (i_sts.scan_done) begin
                    o_cmd.rem_fin = 1'b1;
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_st  = ST_OK;
                    n_state       = S_DONE;
                end
            end
            S_VAL: begin
                o_cmd.res_we   = 1'b1;
                o_cmd.res_st   = ST_OK;
                o_cmd.res_vsel = (i_sts.act == ACT_DEGREE) ? VS_DEG : VS_COL;
                n_state        = S_DONE;
            end
            S_MAX: begin
                o_cmd.scan = SCAN_MAXDEG;
                if (i_sts.scan_done) begin
                    if (i_sts.act == ACT_COLOR) begin
                        o_cmd.color_init = 1'b1;
                        n_state          = S_C_CHK;
                    end else begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_st   = ST_OK;
                        o_cmd.res_vsel = VS_MAX;
                        n_state        = S_DONE;
                    end
                end
            end
            S_C_CHK: begin
                if (i_sts.rank_end) begin
                    o_cmd.res_we = 1'b1;
                    o_cmd.res_st = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rank_clr = 1'b1;
                    n_state        = S_C_SCAN;
                end
            end
            S_C_SCAN: begin
                o_cmd.scan = SCAN_RANK;
                if (i_sts.scan_done) begin
                    n_state = S_C_SEL;
                end
            end
            S_C_SEL: begin
                o_cmd.rd_sel = RD_S;
                if (i_sts.fs) begin
                    n_state = S_C_ROW;
                end else begin
                    o_cmd.rank_inc = 1'b1;
                    n_state        = S_C_CHK;
                end
            end
            S_C_ROW: begin
                o_cmd.row_take = 1'b1;
                n_state        = S_C_NEIGH;
            end
            S_C_NEIGH: begin
                o_cmd.scan = SCAN_NEIGH;
                if (i_sts.scan_done) begin
                    o_cmd.pick_init = 1'b1;
                    n_state         = S_C_PICK;
                end
            end
            S_C_PICK: begin
                if (i_sts.pick_done) begin
                    o_cmd.col_wr   = 1'b1;
                    o_cmd.rank_inc = 1'b1;
                    n_state        = S_C_CHK;
                end else begin
                    o_cmd.pick_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ggc_dp.sv */
// ----------------------------------------------------------------------------
// ggc_dp
// slot memories, sweep counter, counts and result register
// ----------------------------------------------------------------------------
module ggc_dp import ggc_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int ID_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [ID_W-1:0]     i_node_a,
    input  logic [ID_W-1:0]     i_node_b,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [VALUE_W-1:0]  o_value,
    output logic [NCOUNT_W-1:0] o_node_count,
    output logic [ECOUNT_W-1:0] o_edge_count
);

    localparam int SW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int EW = $clog2(MAX_NODES * (MAX_NODES - 1) / 2 + 1);
    localparam int CW = $clog2(MAX_NODES + 2);
    localparam int UW = 1 << CW;
    localparam logic [SW-1:0] LAST = SW'(MAX_NODES - 1);

    // slot memories
    logic [ID_BITS-1:0]   mem_id   [MAX_NODES];
    logic [SW-1:0]        mem_rank [MAX_NODES];
    logic [CW-1:0]        mem_col  [MAX_NODES];
    logic [SW-1:0]        mem_deg  [MAX_NODES];
    logic [MAX_NODES-1:0] mem_adj  [MAX_NODES];

    logic [ID_BITS-1:0]   r_rd_id;
    logic [SW-1:0]        r_rd_rank;
    logic [CW-1:0]        r_rd_col;
    logic [SW-1:0]        r_rd_deg;
    logic [MAX_NODES-1:0] r_rd_row;

    // sweep control
    logic [SW-1:0] r_idx;
    logic          r_halt;
    logic          r_pv;
    logic          r_plast;
    logic [SW-1:0] r_pidx;

    // item and working registers
    logic [ACT_W-1:0]     r_act;
    logic [ID_BITS-1:0]   r_a;
    logic [ID_BITS-1:0]   r_b;
    logic [SW-1:0]        r_sa;
    logic [SW-1:0]        r_sb;
    logic                 r_fa;
    logic                 r_fb;
    logic [SW-1:0]        r_f1;
    logic [SW-1:0]        r_f2;
    logic [1:0]           r_nf;
    logic                 r_a_new;
    logic [SW-1:0]        r_max;
    logic [CW-1:0]        r_limit;
    logic [NW-1:0]        r_rank_cur;
    logic [SW-1:0]        r_s;
    logic                 r_fs;
    logic [UW-1:0]        r_used;
    logic [CW-1:0]        r_c;
    logic [SW-1:0]        r_rem_rank;
    logic [MAX_NODES-1:0] r_row;
    logic [STATUS_W-1:0]  r_res_st;
    logic [VALUE_W-1:0]   r_res_val;

    logic [MAX_NODES-1:0] r_valid;
    logic [NW-1:0]        r_nodes;
    logic [EW-1:0]        r_edges;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_o_status;
    logic [VALUE_W-1:0]   r_o_value;
    logic [NCOUNT_W-1:0]  r_o_nodes;
    logic [ECOUNT_W-1:0]  r_o_edges;

    logic                 w_issue;
    logic [SW-1:0]        w_rd_addr;
    logic                 w_create;
    logic [SW-1:0]        w_cslot;
    logic                 w_sweep;
    logic                 w_set;
    logic [SW-1:0]        w_link_slot;
    logic [MAX_NODES-1:0] w_link_bit;
    logic [MAX_NODES-1:0] w_sa_bit;
    logic                 w_pvalid;
    logic [SW-1:0]        w_max_next;

    logic                 w_id_we;
    logic [ID_BITS-1:0]   w_id_wd;
    logic                 w_rank_we;
    logic [SW-1:0]        w_rank_wa;
    logic [SW-1:0]        w_rank_wd;
    logic                 w_col_we;
    logic [SW-1:0]        w_col_wa;
    logic [CW-1:0]        w_col_wd;
    logic                 w_adj_we;
    logic [SW-1:0]        w_adj_wa;
    logic [SW-1:0]        w_deg_wd;
    logic [MAX_NODES-1:0] w_adj_wd;

    assign w_issue  = (i_cmd.scan != SCAN_NONE) && !r_halt;
    assign w_create = i_cmd.create_a || i_cmd.create_b;
    assign w_cslot  = (i_cmd.create_a || !r_a_new) ? r_f1 : r_f2;
    assign w_sweep  = r_pv && (i_cmd.scan == SCAN_REMOVE);
    assign w_set    = (r_act == ACT_ADD_EDGE);
    assign w_pvalid = r_valid[r_pidx];
    assign w_sa_bit = MAX_NODES'(1) << r_sa;
    assign w_link_slot = i_cmd.link_b ? r_sb : r_sa;
    assign w_link_bit  = MAX_NODES'(1) << (i_cmd.link_b ? r_sa : r_sb);

    // running maximum including the slot returned this cycle
    assign w_max_next = (r_pv && i_cmd.scan == SCAN_MAXDEG && w_pvalid && r_rd_deg > r_max) ?
                        r_rd_deg : r_max;

    always_comb begin
        if (w_issue) begin
            w_rd_addr = r_idx;
        end else begin
            case (i_cmd.rd_sel)
                RD_A:    w_rd_addr = r_sa;
                RD_B:    w_rd_addr = r_sb;
                default: w_rd_addr = r_s;
            endcase
        end
    end

    // write port steering
    always_comb begin
        w_id_we   = w_create;
        w_id_wd   = i_cmd.create_a ? r_a : r_b;

        w_rank_we = 1'b0;
        w_rank_wa = w_cslot;
        w_rank_wd = SW'(r_nodes);
        if (w_create) begin
            w_rank_we = 1'b1;
        end else if (w_sweep && w_pvalid && (r_rd_rank > r_rem_rank)) begin
            w_rank_we = 1'b1;
            w_rank_wa = r_pidx;
            w_rank_wd = r_rd_rank - SW'(1);
        end

        w_col_we = 1'b0;
        w_col_wa = w_cslot;
        w_col_wd = '0;
        if (w_create) begin
            w_col_we = 1'b1;
        end else if (i_cmd.col_wr) begin
            w_col_we = 1'b1;
            w_col_wa = r_s;
            w_col_wd = r_c;
        end

        w_adj_we = 1'b0;
        w_adj_wa = w_cslot;
        w_deg_wd = '0;
        w_adj_wd = '0;
        if (w_create) begin
            w_adj_we = 1'b1;
        end else if (i_cmd.link_wr) begin
            w_adj_we = 1'b1;
            w_adj_wa = w_link_slot;
            w_deg_wd = w_set ? (r_rd_deg + SW'(1)) : (r_rd_deg - SW'(1));
            w_adj_wd = w_set ? (r_rd_row | w_link_bit) : (r_rd_row & ~w_link_bit);
        end else if (w_sweep && w_pvalid && ((r_rd_row & w_sa_bit) != '0)) begin
            w_adj_we = 1'b1;
            w_adj_wa = r_pidx;
            w_deg_wd = r_rd_deg - SW'(1);
            w_adj_wd = r_rd_row & ~w_sa_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_id_we) begin
            mem_id[w_cslot] <= w_id_wd;
        end
        r_rd_id <= mem_id[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rank_we) begin
            mem_rank[w_rank_wa] <= w_rank_wd;
        end
        r_rd_rank <= mem_rank[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_col_we) begin
            mem_col[w_col_wa] <= w_col_wd;
        end
        r_rd_col <= mem_col[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_adj_we) begin
            mem_deg[w_adj_wa] <= w_deg_wd;
        end
        r_rd_deg <= mem_deg[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_adj_we) begin
            mem_adj[w_adj_wa] <= w_adj_wd;
        end
        r_rd_row <= mem_adj[w_rd_addr];
    end

    // sweep counter, one slot issued per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_halt  <= 1'b0;
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
        end else begin
            r_halt  <= (i_cmd.scan != SCAN_NONE) && (r_halt || (w_issue && r_idx == LAST));
            r_pv    <= w_issue;
            r_plast <= w_issue && (r_idx == LAST);
            if (w_issue) begin
                r_idx <= (r_idx == LAST) ? '0 : r_idx + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_a     <= ID_BITS'(i_node_a);
            r_b     <= ID_BITS'(i_node_b);
            r_fa    <= 1'b0;
            r_fb    <= 1'b0;
            r_nf    <= 2'd0;
            r_a_new <= 1'b0;
            r_max   <= '0;
        end
        if (r_pv && i_cmd.scan == SCAN_LOOK) begin
            if (w_pvalid && r_rd_id == r_a) begin
                r_sa <= r_pidx;
                r_fa <= 1'b1;
            end
            if (w_pvalid && r_rd_id == r_b) begin
                r_sb <= r_pidx;
                r_fb <= 1'b1;
            end
            if (!w_pvalid) begin
                if (r_nf == 2'd0) begin
                    r_f1 <= r_pidx;
                    r_nf <= 2'd1;
                end else if (r_nf == 2'd1) begin
                    r_f2 <= r_pidx;
                    r_nf <= 2'd2;
                end
            end
        end
        if (i_cmd.create_a) begin
            r_sa    <= w_cslot;
            r_fa    <= 1'b1;
            r_a_new <= 1'b1;
        end
        if (i_cmd.create_b) begin
            r_sb <= w_cslot;
            r_fb <= 1'b1;
        end
        if (r_pv && i_cmd.scan == SCAN_MAXDEG && w_pvalid && r_rd_deg > r_max) begin
            r_max <= r_rd_deg;
        end
        if (i_cmd.color_init) begin
            r_limit    <= CW'(w_max_next) + CW'(1);
            r_rank_cur <= '0;
        end
        if (i_cmd.rank_inc) begin
            r_rank_cur <= r_rank_cur + NW'(1);
        end
        if (i_cmd.rank_clr) begin
            r_fs   <= 1'b0;
            r_used <= '0;
        end
        if (r_pv && i_cmd.scan == SCAN_RANK && w_pvalid && NW'(r_rd_rank) == r_rank_cur) begin
            r_s  <= r_pidx;
            r_fs <= 1'b1;
        end
        if (i_cmd.row_take) begin
            r_row <= r_rd_row;
        end
        if (r_pv && i_cmd.scan == SCAN_NEIGH && w_pvalid && r_row[r_pidx]) begin
            r_used[r_rd_col] <= 1'b1;
        end
        if (i_cmd.pick_init) begin
            r_c <= CW'(1);
        end else if (i_cmd.pick_step) begin
            r_c <= r_c + CW'(1);
        end
        if (i_cmd.rem_take) begin
            r_rem_rank <= r_rd_rank;
        end
        if (i_cmd.res_we) begin
            r_res_st <= i_cmd.res_st;
            case (i_cmd.res_vsel)
                VS_DEG:  r_res_val <= VALUE_W'(r_rd_deg);
                VS_COL:  r_res_val <= VALUE_W'(r_rd_col);
                VS_MAX:  r_res_val <= VALUE_W'(w_max_next);
                default: r_res_val <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_st;
            r_o_value  <= r_res_val;
            r_o_nodes  <= NCOUNT_W'(r_nodes);
            r_o_edges  <= ECOUNT_W'(r_edges);
        end
    end

    // slot occupancy, counts and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_nodes     <= '0;
            r_edges     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_valid <= '0;
                r_nodes <= '0;
                r_edges <= '0;
            end
            if (w_create) begin
                r_valid[w_cslot] <= 1'b1;
                r_nodes          <= r_nodes + NW'(1);
            end
            if (i_cmd.rem_take) begin
                r_edges <= r_edges - EW'(r_rd_deg);
            end
            if (i_cmd.rem_fin) begin
                r_valid[r_sa] <= 1'b0;
                r_nodes       <= r_nodes - NW'(1);
            end
            if (i_cmd.edge_fin) begin
                r_edges <= w_set ? (r_edges + EW'(1)) : (r_edges - EW'(1));
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.act       = r_act;
    assign o_sts.fa        = r_fa;
    assign o_sts.fb        = r_fb;
    assign o_sts.nf        = r_nf;
    assign o_sts.a_eq_b    = (r_a == r_b);
    assign o_sts.bit_ab    = r_rd_row[r_sb];
    assign o_sts.scan_done = r_plast;
    assign o_sts.rank_end  = (r_rank_cur == r_nodes);
    assign o_sts.fs        = r_fs;
    assign o_sts.pick_done = !((r_c <= r_limit) && r_used[r_c]);
    assign o_sts.out_free  = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_status     = r_o_status;
    assign o_value      = r_o_value;
    assign o_node_count = r_o_nodes;
    assign o_edge_count = r_o_edges;

endmodule

/* rtl/graph_table_greedy_coloring.sv */
// ----------------------------------------------------------------------------
// graph_table_greedy_coloring
// undirected graph table with degree queries and greedy colouring
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | i_valid / o_ready  | i_action, i_node_a, i_node_b
//  result   | o_valid / i_ready  | o_status, o_value, o_node_count, o_edge_count
//
//  one item at a time; o_ready is high only while the sequencer is idle
//  lookups sweep every slot, one per cycle
//  colouring sweeps the slots through the single read port of the slot memories
//  synchronous active-low reset empties the table; no clearing pass is needed
//  a finished result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
module graph_table_greedy_coloring import ggc_pkg::*; #(
    parameter int MAX_NODES = 64,
    parameter int ID_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [ID_W-1:0]     i_node_a,
    input  logic [ID_W-1:0]     i_node_b,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [VALUE_W-1:0]  o_value,
    output logic [NCOUNT_W-1:0] o_node_count,
    output logic [ECOUNT_W-1:0] o_edge_count
);

    // command and status between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: one state per step of an action
    ggc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath: slot memories, sweep counter, counts, result register
    ggc_dp #(
        .MAX_NODES (MAX_NODES),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_action     (i_action),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_node_count (o_node_count),
        .o_edge_count (o_edge_count)
    );

`ifndef NO_ASSERTIONS
    // a new slot is only taken when the lookup found a free one
    a_create_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.create_a || w_cmd.create_b) |-> (w_sts.nf != 2'd0))
        else $error("slot created with no free slot");

    // end of sweep only reported while a sweep is commanded
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.scan_done |-> (w_cmd.scan != SCAN_NONE))
        else $error("sweep end outside a sweep");

    // the result register is never overwritten while a result waits
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over a pending item");

    // the block is busy in the cycle after an item is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after accept");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the graph table with greedy colouring against a behavioural graph
// model kept in the bench: directed cases, a fill to capacity, then random
// graph traffic with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module testbench;
    import ggc_pkg::*;

    localparam int SLOTS       = 64;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [NCOUNT_W-1:0] nodes;
        logic [ECOUNT_W-1:0] edges;
    } t_graph_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [ACT_W-1:0]    i_action;
    logic [ID_W-1:0]     i_node_a;
    logic [ID_W-1:0]     i_node_b;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [VALUE_W-1:0]  o_value;
    logic [NCOUNT_W-1:0] o_node_count;
    logic [ECOUNT_W-1:0] o_edge_count;

    // graph mirror
    bit              node_used [SLOTS];
    logic [ID_W-1:0] node_id   [SLOTS];
    int              node_rank [SLOTS];
    bit [SLOTS-1:0]  links     [SLOTS];
    int              node_col  [SLOTS];
    int              node_total;
    int              edge_total;

    t_graph_result   pending_results[$];
    logic [ID_W-1:0] id_pool[POOL_SIZE];
    int              errors;
    int              items_sent;
    int              results_seen;
    int              colourings;
    int              cycles;
    bit              send_burst;
    bit              recv_burst;

    graph_table_greedy_coloring dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_node_count (o_node_count),
        .o_edge_count (o_edge_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // graph mirror helpers
    // ------------------------------------------------------------------------
    function automatic void wipe_graph();
        for (int s = 0; s < SLOTS; s++) begin
            node_used[s] = 1'b0;
            node_rank[s] = 0;
            links[s]     = '0;
            node_col[s]  = 0;
        end
        node_total = 0;
        edge_total = 0;
    endfunction

    function automatic int slot_of(logic [ID_W-1:0] id);
        for (int s = 0; s < SLOTS; s++)
            if (node_used[s] && node_id[s] == id) return s;
        return -1;
    endfunction

    function automatic int first_empty();
        for (int s = 0; s < SLOTS; s++)
            if (!node_used[s]) return s;
        return -1;
    endfunction

    function automatic void place_node(int s, logic [ID_W-1:0] id);
        node_used[s] = 1'b1;
        node_id[s]   = id;
        node_rank[s] = node_total;
        node_col[s]  = 0;
        links[s]     = '0;
        node_total++;
    endfunction

    function automatic int highest_degree();
        int m;
        m = 0;
        for (int s = 0; s < SLOTS; s++)
            if (node_used[s] && $countones(links[s]) > m) m = $countones(links[s]);
        return m;
    endfunction

    // greedy pass in insertion order, smallest colour not held by a neighbour
    function automatic void greedy_colour();
        int  lim;
        int  s;
        int  c;
        bit  taken;
        lim = highest_degree() + 1;
        for (int r = 0; r < node_total; r++) begin
            s = -1;
            for (int k = 0; k < SLOTS; k++)
                if (node_used[k] && node_rank[k] == r) begin
                    s = k;
                    break;
                end
            if (s < 0) continue;
            for (c = 1; c <= lim; c++) begin
                taken = 1'b0;
                for (int t = 0; t < SLOTS; t++)
                    if (node_used[t] && links[s][t] && node_col[t] == c) begin
                        taken = 1'b1;
                        break;
                    end
                if (!taken) break;
            end
            node_col[s] = c;
        end
    endfunction

    // applies one action to the mirror and returns the result it should give
    function automatic t_graph_result apply_graph_op(logic [ACT_W-1:0] act,
                                                     logic [ID_W-1:0] a,
                                                     logic [ID_W-1:0] b);
        t_graph_result res;
        int            sa;
        int            sb;
        int            s;
        int            need;
        int            rk;
        int            val;
        res = '0;
        val = 0;
        sa  = slot_of(a);
        sb  = slot_of(b);
        case (act)
            ACT_ADD_NODE: begin
                s = first_empty();
                if (sa >= 0) res.status = ST_REJECT;
                else if (s < 0) res.status = ST_FULL;
                else place_node(s, a);
            end
            ACT_ADD_EDGE: begin
                need = (sa < 0 ? 1 : 0) + (sb < 0 ? 1 : 0);
                if (a == b || (sa >= 0 && sb >= 0 && links[sa][sb])) begin
                    res.status = ST_REJECT;
                end else if (node_total + need > SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    if (sa < 0) begin
                        sa = first_empty();
                        place_node(sa, a);
                    end
                    if (sb < 0) begin
                        sb = first_empty();
                        place_node(sb, b);
                    end
                    links[sa][sb] = 1'b1;
                    links[sb][sa] = 1'b1;
                    edge_total++;
                end
            end
            ACT_REM_NODE: begin
                if (sa < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    rk = node_rank[sa];
                    edge_total -= $countones(links[sa]);
                    for (int t = 0; t < SLOTS; t++) begin
                        links[sa][t] = 1'b0;
                        links[t][sa] = 1'b0;
                        if (node_used[t] && node_rank[t] > rk) node_rank[t]--;
                    end
                    node_used[sa] = 1'b0;
                    node_col[sa]  = 0;
                    node_total--;
                end
            end
            ACT_REM_EDGE: begin
                if (sa < 0 || sb < 0 || !links[sa][sb]) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    links[sa][sb] = 1'b0;
                    links[sb][sa] = 1'b0;
                    edge_total--;
                end
            end
            ACT_DEGREE: begin
                if (sa < 0) res.status = ST_NOT_FOUND;
                else val = $countones(links[sa]);
            end
            ACT_MAX_DEGREE: val = highest_degree();
            ACT_COLOR:      greedy_colour();
            ACT_READ_COLOR: begin
                if (sa < 0) res.status = ST_NOT_FOUND;
                else val = node_col[sa];
            end
            ACT_CLEAR:      wipe_graph();
            default:        res.status = ST_REJECT;
        endcase
        res.value = val[VALUE_W-1:0];
        res.nodes = node_total[NCOUNT_W-1:0];
        res.edges = edge_total[ECOUNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // item sender: valid stays up across back-to-back items
    // ------------------------------------------------------------------------
    task automatic send_item(logic [ACT_W-1:0] act, logic [ID_W-1:0] a,
                             logic [ID_W-1:0] b);
        int            gap;
        bit            taken;
        t_graph_result exp_res;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_node_a <= a;
        i_node_b <= b;
        if (act == ACT_COLOR) colourings++;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end
        exp_res = apply_graph_op(act, a, b);
        pending_results = {pending_results, exp_res};
        items_sent++;
    endtask

    // hold off until every result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    initial begin
        t_graph_result want;
        int            stall;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(negedge i_clk);
            while (!o_valid) begin
                @(posedge i_clk);
                @(negedge i_clk);
            end
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: status %0d", o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, o_value);
                    errors++;
                end
                if (o_node_count !== want.nodes) begin
                    $error("node_count: expected %0d, got %0d", want.nodes, o_node_count);
                    errors++;
                end
                if (o_edge_count !== want.edges) begin
                    $error("edge_count: expected %0d, got %0d", want.edges, o_edge_count);
                    errors++;
                end
            end
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every action once, the identifier extremes and each corner case
    task automatic test_directed();
        send_item(ACT_MAX_DEGREE, 16'h0000, 16'h0000);  // empty graph
        send_item(ACT_COLOR, 16'h0000, 16'h0000);       // colour empty graph
        send_item(ACT_ADD_NODE, 16'h0000, 16'hFFFF);
        send_item(ACT_ADD_NODE, 16'hFFFF, 16'h0000);
        send_item(ACT_ADD_NODE, 16'h0000, 16'h5555);    // already present
        send_item(ACT_ADD_EDGE, 16'h0000, 16'hFFFF);
        send_item(ACT_ADD_EDGE, 16'hFFFF, 16'h0000);    // same edge reversed
        send_item(ACT_ADD_EDGE, 16'hAAAA, 16'hAAAA);    // self-loop
        send_item(ACT_ADD_EDGE, 16'h5555, 16'hAAAA);    // both ends missing
        send_item(ACT_ADD_EDGE, 16'h0000, 16'h5555);    // both ends present
        send_item(ACT_DEGREE, 16'h0000, 16'hFFFF);
        send_item(ACT_DEGREE, 16'h1234, 16'h0000);      // absent node
        send_item(ACT_MAX_DEGREE, 16'hFFFF, 16'hFFFF);
        send_item(ACT_READ_COLOR, 16'h5555, 16'h0000);  // new node still colour 0
        send_item(ACT_COLOR, 16'hFFFF, 16'hFFFF);
        send_item(ACT_READ_COLOR, 16'h0000, 16'h0000);
        send_item(ACT_READ_COLOR, 16'hAAAA, 16'h0000);
        send_item(ACT_READ_COLOR, 16'h4321, 16'h0000);  // absent node
        send_item(ACT_REM_EDGE, 16'h5555, 16'h0000);
        send_item(ACT_REM_EDGE, 16'h5555, 16'h0000);    // edge already gone
        send_item(ACT_REM_NODE, 16'h0000, 16'h0000);    // takes its edges along
        send_item(ACT_REM_NODE, 16'h0000, 16'h0000);    // absent node
        send_item(4'd9, 16'h0000, 16'h0000);            // unused codes
        send_item(4'd15, 16'hFFFF, 16'hFFFF);
        send_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
    endtask

    // fill every slot, hit the full cases, colour a dense table
    task automatic test_capacity();
        for (int k = 0; k < SLOTS; k++)
            send_item(ACT_ADD_NODE, 16'(16'h0100 + k * 997), 16'h0000);
        send_item(ACT_ADD_NODE, 16'hBEEF, 16'h0000);              // full
        send_item(ACT_ADD_EDGE, 16'h0100, 16'hBEEF);              // one end missing, full
        for (int k = 1; k < SLOTS; k++)
            send_item(ACT_ADD_EDGE, 16'h0100, 16'(16'h0100 + k * 997));
        for (int k = 2; k < 12; k++)
            send_item(ACT_ADD_EDGE, 16'(16'h0100 + 997), 16'(16'h0100 + k * 997));
        send_item(ACT_MAX_DEGREE, 16'h0000, 16'h0000);
        send_item(ACT_COLOR, 16'h0000, 16'h0000);
        for (int k = 0; k < 4; k++)
            send_item(ACT_READ_COLOR, 16'(16'h0100 + k * 997), 16'h0000);
        send_item(ACT_REM_NODE, 16'(16'h0100 + 5 * 997), 16'h0000);
        send_item(ACT_ADD_EDGE, 16'hBEEF, 16'hCAFE);              // two missing, one free
        send_item(ACT_ADD_EDGE, 16'hBEEF, 16'h0100);              // fills the last slot
        send_item(ACT_COLOR, 16'h0000, 16'h0000);
        send_item(ACT_READ_COLOR, 16'hBEEF, 16'h0000);
        send_item(ACT_CLEAR, 16'h0000, 16'h0000);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 90) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom_range(0, 65535));
    endfunction

    // random graph traffic, edge building the most common action, on a small pool of names
    task automatic test_random(int count);
        int               w;
        logic [ACT_W-1:0] act;
        for (int k = 0; k < count; k++) begin
            if (k % 97 == 0) send_burst = ($urandom_range(0, 3) == 0);
            if (k % 89 == 0) recv_burst = ($urandom_range(0, 3) == 0);
            if (k % 400 == 200) drain_results();
            w = $urandom_range(0, 99);
            if      (w < 12) act = ACT_ADD_NODE;
            else if (w < 42) act = ACT_ADD_EDGE;
            else if (w < 49) act = ACT_REM_NODE;
            else if (w < 58) act = ACT_REM_EDGE;
            else if (w < 68) act = ACT_DEGREE;
            else if (w < 74) act = ACT_MAX_DEGREE;
            else if (w < 78) act = ACT_COLOR;
            else if (w < 95) act = ACT_READ_COLOR;
            else if (w < 97) act = ACT_CLEAR;
            else             act = 4'($urandom_range(9, 15));
            send_item(act, pick_id(), pick_id());
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = '0;
        i_node_a     = '0;
        i_node_b     = '0;
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        colourings   = 0;
        cycles       = 0;
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        wipe_graph();
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int k = 2; k < POOL_SIZE; k++) id_pool[k] = 16'($urandom_range(0, 65535));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_capacity();
        test_random(1330);

        drain_results();
        repeat (50) @(posedge i_clk);
        $display("covered %0d items and %0d results, %0d of them colouring passes",
                 items_sent, results_seen, colourings);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ggc_pkg.sv
rtl/ggc_ctrl.sv
rtl/ggc_dp.sv
rtl/graph_table_greedy_coloring.sv
verif/testbench.sv
